### design/assert_macros.svh
// Assertion macros for the design file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/tbc_pkg.sv
package tbc_pkg;
  localparam int COORD_W = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int EDGE_W = 35;
  localparam int WEIGHT_W = 32;
  // Quotient bits kept by the divider; anything larger saturates.
  localparam int QB = 33;
  localparam int DEF_WEIGHT_FRAC_BITS = 16;
endpackage

### design/triangle_barycentric_coords.sv
// A word passes through the difference, product, edge, setup, divider and output registers in that order.
// Throughput: one word per cycle while the output is not held; a 33-stage restoring divider, one quotient bit
// per stage and three lanes wide, sets the depth.
// Reset clears all valid bits; payload registers are not reset.
`include "assert_macros.svh"
module triangle_barycentric_coords
  import tbc_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic signed [COORD_W-1:0]  vert_a_x,
  input  logic signed [COORD_W-1:0]  vert_a_y,
  input  logic signed [COORD_W-1:0]  vert_b_x,
  input  logic signed [COORD_W-1:0]  vert_b_y,
  input  logic signed [COORD_W-1:0]  vert_c_x,
  input  logic signed [COORD_W-1:0]  vert_c_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WEIGHT_W-1:0] weight_a,
  output logic signed [WEIGHT_W-1:0] weight_b,
  output logic signed [WEIGHT_W-1:0] weight_c,
  output logic                       degenerate
);
  localparam int F = WEIGHT_FRAC_BITS;
  localparam int WW = EDGE_W + ((F > QB) ? F : QB);

  typedef struct packed {
    logic [WW-1:0] rem;
    logic [QB-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]         ln;
    logic [EDGE_W-1:0]   den;
    logic                deg;
  } div_st_t;

  // The whole pipeline moves unless the output word is held.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 0: truncate the point toward zero and form coordinate differences.
  function automatic logic signed [COORD_W-1:0] trunc_pix(logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] m;
    m = {v[COORD_W-1:4], 4'b0000};
    if (v[COORD_W-1] && (v[3:0] != 4'b0000)) begin
      m = m + COORD_W'(16);
    end
    return m;
  endfunction

  function automatic logic signed [DIFF_W-1:0] dif(logic signed [COORD_W-1:0] u,
                                                   logic signed [COORD_W-1:0] w);
    return DIFF_W'(u) - DIFF_W'(w);
  endfunction

  logic signed [COORD_W-1:0] px, py;
  assign px = trunc_pix(point_x);
  assign py = trunc_pix(point_y);

  logic v0;
  logic signed [DIFF_W-1:0] bcx, bcy, cax, cay, abx, aby;
  logic signed [DIFF_W-1:0] pcx, pcy, pax, pay, pbx, pby, acx, acy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
    if (adv) begin
      bcx <= dif(vert_b_x, vert_c_x);
      bcy <= dif(vert_b_y, vert_c_y);
      cax <= dif(vert_c_x, vert_a_x);
      cay <= dif(vert_c_y, vert_a_y);
      abx <= dif(vert_a_x, vert_b_x);
      aby <= dif(vert_a_y, vert_b_y);
      pcx <= dif(px, vert_c_x);
      pcy <= dif(py, vert_c_y);
      pax <= dif(px, vert_a_x);
      pay <= dif(py, vert_a_y);
      pbx <= dif(px, vert_b_x);
      pby <= dif(py, vert_b_y);
      acx <= dif(vert_a_x, vert_c_x);
      acy <= dif(vert_a_y, vert_c_y);
    end
  end

  // Stage 1: the eight partial products of the four cross products.
  logic v1;
  logic signed [PROD_W-1:0] pa0, pa1, pb0, pb1, pc0, pc1, pe0, pe1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      pa0 <= bcx * pcy;
      pa1 <= bcy * pcx;
      pb0 <= cax * pay;
      pb1 <= cay * pax;
      pc0 <= abx * pby;
      pc1 <= aby * pbx;
      pe0 <= bcx * acy;
      pe1 <= bcy * acx;
    end
  end

  // Stage 2: edge functions and doubled area.
  logic v2;
  logic signed [EDGE_W-1:0] ea, eb, ec, earea;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      ea    <= EDGE_W'(pa0) - EDGE_W'(pa1);
      eb    <= EDGE_W'(pb0) - EDGE_W'(pb1);
      ec    <= EDGE_W'(pc0) - EDGE_W'(pc1);
      earea <= EDGE_W'(pe0) - EDGE_W'(pe1);
    end
  end

  // Stage 3: magnitudes, result signs, the flat-triangle flag and the overflow check for each lane.
  logic [EDGE_W-1:0] den_mag;
  logic [WW-1:0]     den_top;
  logic [EDGE_W-1:0] num_mag [3];
  logic              num_sgn [3];
  div_st_t           st0_next;

  assign den_mag = earea[EDGE_W-1] ? EDGE_W'(-earea) : EDGE_W'(earea);
  assign den_top = WW'(den_mag) << QB;
  assign num_mag[0] = ea[EDGE_W-1] ? EDGE_W'(-ea) : EDGE_W'(ea);
  assign num_mag[1] = eb[EDGE_W-1] ? EDGE_W'(-eb) : EDGE_W'(eb);
  assign num_mag[2] = ec[EDGE_W-1] ? EDGE_W'(-ec) : EDGE_W'(ec);
  assign num_sgn[0] = ea[EDGE_W-1];
  assign num_sgn[1] = eb[EDGE_W-1];
  assign num_sgn[2] = ec[EDGE_W-1];

  always_comb begin
    st0_next.den = den_mag;
    st0_next.deg = (earea == '0);
    for (int l = 0; l < 3; l++) begin
      st0_next.ln[l].rem = WW'(num_mag[l]) << F;
      st0_next.ln[l].q   = '0;
      st0_next.ln[l].neg = num_sgn[l] ^ earea[EDGE_W-1];
      st0_next.ln[l].ovf = ((WW'(num_mag[l]) << F) >= den_top);
    end
  end

  div_st_t st [QB+1];
  logic    sv [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v2;
    end
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  // Divider stages: stage k settles quotient bit QB-1-k in each lane.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [WW-1:0] dsh;
    div_st_t       nxt;

    assign dsh = WW'(st[k].den) << SH;

    always_comb begin
      nxt = st[k];
      for (int l = 0; l < 3; l++) begin
        if (st[k].ln[l].rem >= dsh) begin
          nxt.ln[l].rem = st[k].ln[l].rem - dsh;
          nxt.ln[l].q   = {st[k].ln[l].q[QB-2:0], 1'b1};
        end else begin
          nxt.ln[l].q   = {st[k].ln[l].q[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
      if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  // Output stage: apply sign, saturate and force zero on a flat triangle.
  function automatic logic [WEIGHT_W-1:0] sat_w(lane_t x, logic deg);
    logic [WEIGHT_W-1:0] r;
    logic [QB-1:0]       lim;
    if (deg) begin
      r = '0;
    end else if (x.neg) begin
      lim = QB'(1) << (WEIGHT_W - 1);
      if (x.ovf || (x.q > lim)) begin
        r = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
        r = WEIGHT_W'(-x.q);
      end
    end else begin
      lim = (QB'(1) << (WEIGHT_W - 1)) - QB'(1);
      if (x.ovf || (x.q > lim)) begin
        r = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
        r = WEIGHT_W'(x.q);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[QB];
    end
    if (adv) begin
      weight_a   <= sat_w(st[QB].ln[0], st[QB].deg);
      weight_b   <= sat_w(st[QB].ln[1], st[QB].deg);
      weight_c   <= sat_w(st[QB].ln[2], st[QB].deg);
      degenerate <= st[QB].deg;
    end
  end

  // Checks on the pipeline control and the flat-triangle result.
  `ASSERT_HOLDS(a_flat_zero, !(out_valid && degenerate) || ((weight_a == '0) && (weight_b == '0) && (weight_c == '0)), "flat triangle with nonzero weight")
  `ASSERT_HOLDS(a_stall_link, in_stall == (out_valid && out_stall), "input stall not tied to held output")
  `ASSERT_NEXT(a_hold_tail, !adv && sv[QB], sv[QB] && $stable(st[QB].ln[0].q), "divider tail moved while held")
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top
  import tbc_pkg::*;
();

  localparam int FRAC = DEF_WEIGHT_FRAC_BITS;
  localparam int LATENCY = 37;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [COORD_W-1:0] px, py, ax, ay, bx, by, cx, cy;
  } query_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] wa, wb, wc;
    logic degen;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] point_x = '0, point_y = '0;
  logic signed [COORD_W-1:0] vert_a_x = '0, vert_a_y = '0;
  logic signed [COORD_W-1:0] vert_b_x = '0, vert_b_y = '0;
  logic signed [COORD_W-1:0] vert_c_x = '0, vert_c_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WEIGHT_W-1:0] weight_a, weight_b, weight_c;
  logic degenerate;

  weights_t pending_weights[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  triangle_barycentric_coords uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y),
    .vert_a_x(vert_a_x), .vert_a_y(vert_a_y),
    .vert_b_x(vert_b_x), .vert_b_y(vert_b_y),
    .vert_c_x(vert_c_x), .vert_c_y(vert_c_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
    .degenerate(degenerate)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clear the fraction bits on the magnitude so negatives move toward zero.
  function automatic longint to_pixel(input logic signed [COORD_W-1:0] v);
    longint x;
    x = v;
    if (x >= 0) return x & ~longint'(15);
    return -((-x) & ~longint'(15));
  endfunction

  // Cross product (u - v) x (q - v).
  function automatic longint edge_fn(input longint ux, uy, vx, vy, qx, qy);
    return (ux - vx) * (qy - vy) - (uy - vy) * (qx - vx);
  endfunction

  // Scaled quotient rounded toward zero, saturated to 32 bits.
  function automatic logic [WEIGHT_W-1:0] scaled_ratio(input longint num, den);
    logic neg;
    longint unsigned n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << FRAC) / d;
    if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic weights_t barycentric(input query_t t);
    weights_t w;
    longint px, py, area;
    px = to_pixel(t.px);
    py = to_pixel(t.py);
    area = edge_fn(t.bx, t.by, t.cx, t.cy, t.ax, t.ay);
    w = '0;
    if (area == 0) begin
      w.degen = 1'b1;
    end else begin
      w.wa = scaled_ratio(edge_fn(t.bx, t.by, t.cx, t.cy, px, py), area);
      w.wb = scaled_ratio(edge_fn(t.cx, t.cy, t.ax, t.ay, px, py), area);
      w.wc = scaled_ratio(edge_fn(t.ax, t.ay, t.bx, t.by, px, py), area);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [WEIGHT_W-1:0] got, exp);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
    error_count++;
  endtask

  // Offer one word, idling at random first, and wait until it is taken.
  // The valid stays high after acceptance so words can follow back to back.
  task automatic send_word(input query_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {point_x, point_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y} <= t;
    pending_weights.push_back(barycentric(t));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(3) == 0 ? 16'h8000 : 16'h7FFF;
      1: return COORD_W'($signed($urandom_range(512)) - 256);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Fields at their extremes, collinear and repeated vertices, saturation, negative truncation.
  task automatic test_directed();
    query_t t;
    t = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000,
          16'sh0000, 16'sh0100};
    send_word(t);
    t.px = 16'shFFF7; t.py = -16'sh0021;
    send_word(t);
    t = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'sh8000, 16'sh7FFF};
    send_word(t);
    t = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'sh7FFF, 16'sh8000};
    send_word(t);
    // Zero area: all three vertices equal, then collinear.
    t = '{16'sh0010, 16'sh0020, 16'sh0030, 16'sh0030, 16'sh0030, 16'sh0030,
          16'sh0030, 16'sh0030};
    send_word(t);
    t = '{16'sh0010, 16'sh0020, 16'sh0000, 16'sh0000, 16'sh0010, 16'sh0010,
          16'sh0020, 16'sh0020};
    send_word(t);
    // Tiny area with a far point drives the weights into saturation.
    t = '{16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000,
          16'sh0000, 16'sh0001};
    send_word(t);
    t = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000,
          16'sh0000, 16'sh0001};
    send_word(t);
    t = '{16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001,
          16'sh0001, 16'sh0000};
    send_word(t);
    t = '{16'shFFFF, 16'sh000F, 16'sh0000, 16'sh0000, 16'sh0010, 16'sh0000,
          16'sh0000, 16'sh0010};
    send_word(t);
    drain_pipe();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    query_t t;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      t.px = rand_coord(); t.py = rand_coord();
      t.ax = rand_coord(); t.ay = rand_coord();
      t.bx = rand_coord(); t.by = rand_coord();
      if ($urandom_range(9) == 0) begin
        t.cx = t.ax; t.cy = t.ay;
      end else begin
        t.cx = rand_coord(); t.cy = rand_coord();
      end
      send_word(t);
    end
    drain_pipe();
  endtask

  // Hold the output for a long stretch so the pipe fills and stalls its input.
  task automatic test_backpressure();
    query_t t;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles <= 150;
    repeat (120) begin
      t = query_t'({$urandom, $urandom, $urandom, $urandom});
      send_word(t);
    end
    drain_pipe();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(550, 9, 62);
    test_random(550, 62, 9);
    test_backpressure();
    test_random(500, 0, 0);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver stall: a counted long hold when asked, else random idling.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted word against the oldest expectation.
  always @(posedge clk) begin
    weights_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected word", weight_a, '0);
      end else begin
        w = pending_weights.pop_front();
        if (weight_a !== w.wa) report_mismatch("weight_a", weight_a, w.wa);
        if (weight_b !== w.wb) report_mismatch("weight_b", weight_b, w.wb);
        if (weight_c !== w.wc) report_mismatch("weight_c", weight_c, w.wc);
        if (degenerate !== w.degen) begin
          report_mismatch("degenerate", WEIGHT_W'(degenerate), WEIGHT_W'(w.degen));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT with %0d words outstanding", pending_weights.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule

### triangle_barycentric_coords.f
+incdir+design
design/tbc_pkg.sv
design/triangle_barycentric_coords.sv
verif/tb_top.sv
